### rtl/rsi_pkg.sv
// ----------------------------------------------------------------------------
// rsi_pkg
// Shared widths, codes and types for the ray-sphere intersection core.
// ----------------------------------------------------------------------------
`default_nettype none

package rsi_pkg;

    // coordinate width: default and the widest that the datapath honors
    localparam int CoordWidthDef = 16;
    localparam int CoordMax      = 16;
    localparam int RadW          = 15;

    // datapath widths
    localparam int DiffW  = 17;   // e - c
    localparam int AW     = 32;   // v.v
    localparam int BW     = 34;   // v.d, signed
    localparam int CW     = 35;   // d.d - r^2, signed
    localparam int BMagW  = 33;
    localparam int CMagW  = 34;
    localparam int ProdW  = 66;   // B*B and A*|C|
    localparam int DiscW  = 67;   // quarter discriminant
    localparam int SqrtW  = 50;   // floor(sqrt(D * 2^32))
    localparam int SqInW  = 100;
    localparam int RemW   = 52;
    localparam int NumW   = 52;   // root numerator
    localparam int QW     = 32;   // quotient bits
    localparam int TW     = 32;   // Q16.16 distance
    localparam int CntW   = 2;
    localparam int EpsW   = 16;

    // root count codes
    localparam logic [CntW-1:0] CntNone = 2'd0;
    localparam logic [CntW-1:0] CntOne  = 2'd1;
    localparam logic [CntW-1:0] CntTwo  = 2'd2;

    // saturation limits
    localparam logic [TW-1:0] TMin = 32'h8000_0000;
    localparam logic [TW-1:0] TMax = 32'h7FFF_FFFF;

    // configuration port
    localparam int                ApbAddrW = 3;
    localparam int                ApbDataW = 32;
    localparam logic              RegEps   = 1'b0;   // register index, paddr[2]
    localparam logic [EpsW-1:0]   EpsReset = 16'd66;

    typedef struct packed {
        logic [AW-1:0]        a;
        logic signed [BW-1:0] b;
        logic [CntW-1:0]      cnt;
    } t_meta;

    typedef struct packed {
        logic [TW-1:0]   t1;
        logic [TW-1:0]   t2;
        logic            b_pos;
        logic [CntW-1:0] cnt;
    } t_roots;

endpackage

`default_nettype wire

### rtl/rsi_if.sv
// ----------------------------------------------------------------------------
// rsi_if
// Valid/ready channels for ray words and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface rsi_ray_if #(
    parameter int COORD_WIDTH = rsi_pkg::CoordWidthDef
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] center_x;
    logic signed [COORD_WIDTH-1:0] center_y;
    logic signed [COORD_WIDTH-1:0] center_z;
    logic [rsi_pkg::RadW-1:0]      radius;
    logic signed [COORD_WIDTH-1:0] origin_x;
    logic signed [COORD_WIDTH-1:0] origin_y;
    logic signed [COORD_WIDTH-1:0] origin_z;
    logic signed [COORD_WIDTH-1:0] dir_x;
    logic signed [COORD_WIDTH-1:0] dir_y;
    logic signed [COORD_WIDTH-1:0] dir_z;

    modport source (
        output valid, center_x, center_y, center_z, radius,
               origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
        input  ready
    );
    modport sink (
        input  valid, center_x, center_y, center_z, radius,
               origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
        output ready
    );
endinterface

interface rsi_res_if;
    logic                          valid;
    logic                          ready;
    logic                          hit;
    logic [rsi_pkg::CntW-1:0]      root_count;
    logic signed [rsi_pkg::TW-1:0] near_t;
    logic signed [rsi_pkg::TW-1:0] far_t;

    modport source (output valid, hit, root_count, near_t, far_t, input ready);
    modport sink   (input valid, hit, root_count, near_t, far_t, output ready);
endinterface

`default_nettype wire

### rtl/rsi_quad.sv
// ----------------------------------------------------------------------------
// rsi_quad
// Quadratic coefficients and quarter discriminant, seven register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module rsi_quad #(
    parameter int COORD_WIDTH = rsi_pkg::CoordWidthDef
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_en,
    input  wire logic                           i_valid,
    input  wire logic signed [COORD_WIDTH-1:0]  i_center [3],
    input  wire logic signed [COORD_WIDTH-1:0]  i_origin [3],
    input  wire logic signed [COORD_WIDTH-1:0]  i_dir    [3],
    input  wire logic [rsi_pkg::RadW-1:0]       i_radius,
    output logic                                o_valid,
    output rsi_pkg::t_meta                      o_meta,
    output logic [rsi_pkg::DiscW-1:0]           o_disc
);
    localparam int ExtW = (COORD_WIDTH > rsi_pkg::CoordMax) ? rsi_pkg::CoordMax : COORD_WIDTH;
    localparam int CW16 = rsi_pkg::CoordMax;

    logic signed [CW16-1:0] w_c [3];
    logic signed [CW16-1:0] w_o [3];
    logic signed [CW16-1:0] w_v [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_c[k] = CW16'($signed(i_center[k][ExtW-1:0]));
            w_o[k] = CW16'($signed(i_origin[k][ExtW-1:0]));
            w_v[k] = CW16'($signed(i_dir[k][ExtW-1:0]));
        end
    end

    // stage 1: offset from sphere center
    logic [6:0] r_valid;
    logic signed [rsi_pkg::DiffW-1:0] r1_d [3];
    logic signed [CW16-1:0]           r1_v [3];
    logic [rsi_pkg::RadW-1:0]         r1_rad;

    // stage 2: products
    logic signed [31:0] r2_vv [3];
    logic signed [32:0] r2_vd [3];
    logic signed [33:0] r2_dd [3];
    logic signed [30:0] r2_rr;

    // stage 3: coefficients
    logic [rsi_pkg::AW-1:0]        r3_a;
    logic signed [rsi_pkg::BW-1:0] r3_b;
    logic signed [rsi_pkg::CW-1:0] r3_c;

    // stage 4: magnitudes
    logic [rsi_pkg::AW-1:0]        r4_a;
    logic signed [rsi_pkg::BW-1:0] r4_b;
    logic [rsi_pkg::BMagW-1:0]     r4_bmag;
    logic [rsi_pkg::CMagW-1:0]     r4_cmag;
    logic                          r4_cpos;

    // stage 5: partial products
    logic [31:0]                   r5_bhh;
    logic [32:0]                   r5_bhl;
    logic [33:0]                   r5_bll;
    logic [48:0]                   r5_ach;
    logic [48:0]                   r5_acl;
    logic [rsi_pkg::AW-1:0]        r5_a;
    logic signed [rsi_pkg::BW-1:0] r5_b;
    logic                          r5_cpos;

    // stage 6: B*B and A*|C|
    logic [rsi_pkg::ProdW-1:0]     r6_bb;
    logic [rsi_pkg::ProdW-1:0]     r6_ac;
    logic [rsi_pkg::AW-1:0]        r6_a;
    logic signed [rsi_pkg::BW-1:0] r6_b;
    logic                          r6_cpos;

    // stage 7: discriminant
    rsi_pkg::t_meta                r7_meta;
    logic [rsi_pkg::DiscW-1:0]     r7_disc;

    logic [15:0] w_bh;
    logic [16:0] w_bl;
    logic [16:0] w_ch;
    logic [16:0] w_cl;
    logic [rsi_pkg::DiscW-1:0] w_sum;
    logic [rsi_pkg::DiscW-1:0] w_diff;
    rsi_pkg::t_meta            n_meta;
    logic [rsi_pkg::DiscW-1:0] n_disc;

    assign w_bh = r4_bmag[32:17];
    assign w_bl = r4_bmag[16:0];
    assign w_ch = r4_cmag[33:17];
    assign w_cl = r4_cmag[16:0];

    assign w_sum  = rsi_pkg::DiscW'(r6_bb) + rsi_pkg::DiscW'(r6_ac);
    assign w_diff = rsi_pkg::DiscW'(r6_bb) - rsi_pkg::DiscW'(r6_ac);

    always_comb begin
        n_meta.a   = r6_a;
        n_meta.b   = r6_b;
        n_meta.cnt = rsi_pkg::CntNone;
        n_disc     = '0;
        if (r6_a == '0) begin
            n_meta.cnt = rsi_pkg::CntNone;
        end else if (!r6_cpos) begin
            n_disc     = w_sum;
            n_meta.cnt = (w_sum != '0) ? rsi_pkg::CntTwo : rsi_pkg::CntOne;
        end else if (w_diff[rsi_pkg::DiscW-1]) begin
            n_meta.cnt = rsi_pkg::CntNone;
        end else begin
            n_disc     = w_diff;
            n_meta.cnt = (w_diff != '0) ? rsi_pkg::CntTwo : rsi_pkg::CntOne;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[5:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r1_d[k] <= rsi_pkg::DiffW'(w_o[k]) - rsi_pkg::DiffW'(w_c[k]);
                r1_v[k] <= w_v[k];
                r2_vv[k] <= 32'(r1_v[k]) * 32'(r1_v[k]);
                r2_vd[k] <= 33'(r1_v[k]) * 33'(r1_d[k]);
                r2_dd[k] <= 34'(r1_d[k]) * 34'(r1_d[k]);
            end
            r1_rad <= i_radius;
            r2_rr  <= 31'(r1_rad) * 31'(r1_rad);

            r3_a <= rsi_pkg::AW'($unsigned(r2_vv[0])) + rsi_pkg::AW'($unsigned(r2_vv[1]))
                  + rsi_pkg::AW'($unsigned(r2_vv[2]));
            r3_b <= rsi_pkg::BW'(r2_vd[0]) + rsi_pkg::BW'(r2_vd[1]) + rsi_pkg::BW'(r2_vd[2]);
            r3_c <= rsi_pkg::CW'(r2_dd[0]) + rsi_pkg::CW'(r2_dd[1]) + rsi_pkg::CW'(r2_dd[2])
                  - rsi_pkg::CW'(r2_rr);

            r4_a    <= r3_a;
            r4_b    <= r3_b;
            r4_bmag <= r3_b[rsi_pkg::BW-1] ? rsi_pkg::BMagW'(-r3_b) : rsi_pkg::BMagW'(r3_b);
            r4_cmag <= r3_c[rsi_pkg::CW-1] ? rsi_pkg::CMagW'(-r3_c) : rsi_pkg::CMagW'(r3_c);
            r4_cpos <= !r3_c[rsi_pkg::CW-1] && (r3_c != '0);

            r5_bhh  <= 32'(w_bh) * 32'(w_bh);
            r5_bhl  <= 33'(w_bh) * 33'(w_bl);
            r5_bll  <= 34'(w_bl) * 34'(w_bl);
            r5_ach  <= 49'(r4_a) * 49'(w_ch);
            r5_acl  <= 49'(r4_a) * 49'(w_cl);
            r5_a    <= r4_a;
            r5_b    <= r4_b;
            r5_cpos <= r4_cpos;

            r6_bb   <= (rsi_pkg::ProdW'(r5_bhh) << 34) + (rsi_pkg::ProdW'(r5_bhl) << 18)
                     + rsi_pkg::ProdW'(r5_bll);
            r6_ac   <= (rsi_pkg::ProdW'(r5_ach) << 17) + rsi_pkg::ProdW'(r5_acl);
            r6_a    <= r5_a;
            r6_b    <= r5_b;
            r6_cpos <= r5_cpos;

            r7_meta <= n_meta;
            r7_disc <= n_disc;
        end
    end

    assign o_valid = r_valid[6];
    assign o_meta  = r7_meta;
    assign o_disc  = r7_disc;

endmodule

`default_nettype wire

### rtl/rsi_sqrt.sv
// ----------------------------------------------------------------------------
// rsi_sqrt
// Pipelined digit-by-digit square root, one result bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rsi_sqrt (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_en,
    input  wire logic                       i_valid,
    input  wire logic [rsi_pkg::DiscW-1:0]  i_disc,
    input  wire rsi_pkg::t_meta             i_meta,
    output logic                            o_valid,
    output logic [rsi_pkg::SqrtW-1:0]       o_root,
    output rsi_pkg::t_meta                  o_meta
);
    localparam int N    = rsi_pkg::SqrtW;
    localparam int XW   = rsi_pkg::SqInW;
    localparam int RW   = rsi_pkg::RemW;
    localparam int ShW  = rsi_pkg::RemW + 2;
    localparam int PadW = XW - rsi_pkg::DiscW - 32;

    logic                r_valid [N];
    logic [XW-1:0]       r_x     [N];
    logic [RW-1:0]       r_rem   [N];
    logic [N-1:0]        r_res   [N];
    rsi_pkg::t_meta      r_meta  [N];

    logic                c_valid [N];
    logic [XW-1:0]       c_x     [N];
    logic [RW-1:0]       c_rem   [N];
    logic [N-1:0]        c_res   [N];
    rsi_pkg::t_meta      c_meta  [N];

    logic [RW-1:0]       n_rem   [N];
    logic [N-1:0]        n_res   [N];

    assign c_valid[0] = i_valid;
    assign c_x[0]     = {{PadW{1'b0}}, i_disc, 32'b0};
    assign c_rem[0]   = '0;
    assign c_res[0]   = '0;
    assign c_meta[0]  = i_meta;

    for (genvar k = 1; k < N; k++) begin : g_link
        assign c_valid[k] = r_valid[k-1];
        assign c_x[k]     = r_x[k-1];
        assign c_rem[k]   = r_rem[k-1];
        assign c_res[k]   = r_res[k-1];
        assign c_meta[k]  = r_meta[k-1];
    end

    // take the next two radicand bits, try (2*res)*2 + 1
    always_comb begin
        logic [ShW-1:0] sh;
        logic [ShW-1:0] tr;
        for (int k = 0; k < N; k++) begin
            sh = {c_rem[k], c_x[k][2*(N-1-k) +: 2]};
            tr = ShW'({c_res[k], 2'b01});
            if (sh >= tr) begin
                n_rem[k] = RW'(sh - tr);
                n_res[k] = {c_res[k][N-2:0], 1'b1};
            end else begin
                n_rem[k] = RW'(sh);
                n_res[k] = {c_res[k][N-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < N; k++) begin
                r_valid[k] <= 1'b0;
            end
        end else if (i_en) begin
            for (int k = 0; k < N; k++) begin
                r_valid[k] <= c_valid[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < N; k++) begin
                r_x[k]    <= c_x[k];
                r_rem[k]  <= n_rem[k];
                r_res[k]  <= n_res[k];
                r_meta[k] <= c_meta[k];
            end
        end
    end

    assign o_valid = r_valid[N-1];
    assign o_root  = r_res[N-1];
    assign o_meta  = r_meta[N-1];

endmodule

`default_nettype wire

### rtl/rsi_div.sv
// ----------------------------------------------------------------------------
// rsi_div
// Both roots: numerators, rounding bias, pipelined restoring divide, clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module rsi_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_en,
    input  wire logic                       i_valid,
    input  wire logic [rsi_pkg::SqrtW-1:0]  i_root,
    input  wire rsi_pkg::t_meta             i_meta,
    output logic                            o_valid,
    output rsi_pkg::t_roots                 o_roots
);
    localparam int N  = rsi_pkg::QW;
    localparam int AW = rsi_pkg::AW;
    localparam int NW = rsi_pkg::NumW;

    function automatic logic [rsi_pkg::TW-1:0] clamp(input logic [N-1:0] q,
                                                     input logic neg, input logic ovf);
        logic [rsi_pkg::TW-1:0] t;
        if (neg) begin
            t = (ovf || q > rsi_pkg::TMin) ? rsi_pkg::TMin : rsi_pkg::TW'(-q);
        end else begin
            t = (ovf || q > rsi_pkg::TMax) ? rsi_pkg::TMax : rsi_pkg::TW'(q);
        end
        return t;
    endfunction

    logic signed [NW-1:0] w_nb;
    logic signed [NW-1:0] w_s;

    assign w_nb = -(NW'(i_meta.b) <<< 16);
    assign w_s  = $signed(NW'(i_root));

    // front stages: numerators, magnitudes plus half divisor, overflow test
    logic [2:0]                r_fv;
    logic signed [NW-1:0]      r0_n   [2];
    logic [NW-1:0]             r1_num [2];
    logic                      r1_neg [2];
    logic [AW-1:0]             r2_rem [2];
    logic [N-1:0]              r2_lq  [2];
    logic                      r2_ovf [2];
    logic                      r2_neg [2];
    logic [AW-1:0]             r_fa   [3];
    logic                      r_fbp  [3];
    logic [rsi_pkg::CntW-1:0]  r_fcnt [3];

    // divide stages
    logic                      r_valid [N];
    logic [AW-1:0]             r_rem   [N][2];
    logic [N-1:0]              r_lq    [N][2];
    logic                      r_ovf   [N][2];
    logic                      r_neg   [N][2];
    logic [AW-1:0]             r_a     [N];
    logic                      r_bp    [N];
    logic [rsi_pkg::CntW-1:0]  r_cnt   [N];

    logic                      c_valid [N];
    logic [AW-1:0]             c_rem   [N][2];
    logic [N-1:0]              c_lq    [N][2];
    logic                      c_ovf   [N][2];
    logic                      c_neg   [N][2];
    logic [AW-1:0]             c_a     [N];
    logic                      c_bp    [N];
    logic [rsi_pkg::CntW-1:0]  c_cnt   [N];

    logic [AW-1:0]             n_rem   [N][2];
    logic [N-1:0]              n_lq    [N][2];

    logic                      r_ov;
    rsi_pkg::t_roots           r_roots;

    assign c_valid[0] = r_fv[2];
    assign c_a[0]     = r_fa[2];
    assign c_bp[0]    = r_fbp[2];
    assign c_cnt[0]   = r_fcnt[2];
    for (genvar l = 0; l < 2; l++) begin : g_in
        assign c_rem[0][l] = r2_rem[l];
        assign c_lq[0][l]  = r2_lq[l];
        assign c_ovf[0][l] = r2_ovf[l];
        assign c_neg[0][l] = r2_neg[l];
    end

    for (genvar k = 1; k < N; k++) begin : g_link
        assign c_valid[k] = r_valid[k-1];
        assign c_a[k]     = r_a[k-1];
        assign c_bp[k]    = r_bp[k-1];
        assign c_cnt[k]   = r_cnt[k-1];
        for (genvar l = 0; l < 2; l++) begin : g_lane
            assign c_rem[k][l] = r_rem[k-1][l];
            assign c_lq[k][l]  = r_lq[k-1][l];
            assign c_ovf[k][l] = r_ovf[k-1][l];
            assign c_neg[k][l] = r_neg[k-1][l];
        end
    end

    // shift in one dividend bit, subtract divisor when it fits, shift in quotient bit
    always_comb begin
        logic [AW:0] sh;
        logic        ge;
        for (int k = 0; k < N; k++) begin
            for (int l = 0; l < 2; l++) begin
                sh = {c_rem[k][l], c_lq[k][l][N-1]};
                ge = (sh >= {1'b0, c_a[k]});
                n_rem[k][l] = ge ? AW'(sh - {1'b0, c_a[k]}) : AW'(sh);
                n_lq[k][l]  = {c_lq[k][l][N-2:0], ge};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= '0;
            r_ov <= 1'b0;
            for (int k = 0; k < N; k++) begin
                r_valid[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_fv <= {r_fv[1:0], i_valid};
            r_ov <= r_valid[N-1];
            for (int k = 0; k < N; k++) begin
                r_valid[k] <= c_valid[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_n[0]   <= w_nb - w_s;
            r0_n[1]   <= w_nb + w_s;
            r_fa[0]   <= i_meta.a;
            r_fbp[0]  <= !i_meta.b[rsi_pkg::BW-1] && (i_meta.b != '0);
            r_fcnt[0] <= i_meta.cnt;
            for (int j = 1; j < 3; j++) begin
                r_fa[j]   <= r_fa[j-1];
                r_fbp[j]  <= r_fbp[j-1];
                r_fcnt[j] <= r_fcnt[j-1];
            end
            for (int l = 0; l < 2; l++) begin
                r1_neg[l] <= r0_n[l][NW-1];
                r1_num[l] <= (r0_n[l][NW-1] ? NW'(-r0_n[l]) : NW'(r0_n[l]))
                           + NW'(r_fa[0][AW-1:1]);
                r2_rem[l] <= AW'(r1_num[l][NW-1:N]);
                r2_lq[l]  <= r1_num[l][N-1:0];
                r2_ovf[l] <= AW'(r1_num[l][NW-1:N]) >= r_fa[1];
                r2_neg[l] <= r1_neg[l];
            end
            for (int k = 0; k < N; k++) begin
                r_a[k]   <= c_a[k];
                r_bp[k]  <= c_bp[k];
                r_cnt[k] <= c_cnt[k];
                for (int l = 0; l < 2; l++) begin
                    r_rem[k][l] <= n_rem[k][l];
                    r_lq[k][l]  <= n_lq[k][l];
                    r_ovf[k][l] <= c_ovf[k][l];
                    r_neg[k][l] <= c_neg[k][l];
                end
            end
            r_roots.t1    <= clamp(r_lq[N-1][0], r_neg[N-1][0], r_ovf[N-1][0]);
            r_roots.t2    <= clamp(r_lq[N-1][1], r_neg[N-1][1], r_ovf[N-1][1]);
            r_roots.b_pos <= r_bp[N-1];
            r_roots.cnt   <= r_cnt[N-1];
        end
    end

    assign o_valid = r_ov;
    assign o_roots = r_roots;

endmodule

`default_nettype wire

### rtl/ray_sphere_intersect_core.sv
// ----------------------------------------------------------------------------
// ray_sphere_intersect_core
// Ray-sphere hit test: discriminant, square root, both roots in Q16.16.
// ----------------------------------------------------------------------------
// Pipeline: 7 coefficient stages, 50 square-root stages, 36 divide stages and
//   1 output register between an accepted ray word and its result word.
// Throughput: one word per cycle; the whole pipe holds while the output
//   register is full and not taken.
// Reset: synchronous, active low; clears all valid bits and loads hit_epsilon
//   with its default. No memories, no clearing pass.
`default_nettype none

module ray_sphere_intersect_core #(
    parameter int COORD_WIDTH = rsi_pkg::CoordWidthDef
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    rsi_ray_if.sink                            i_ray,
    rsi_res_if.source                          o_res,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [rsi_pkg::ApbAddrW-1:0]  paddr,
    input  wire logic [rsi_pkg::ApbDataW-1:0]  pwdata,
    output logic [rsi_pkg::ApbDataW-1:0]       prdata,
    output logic                               pready
);
    // Register file: hit_epsilon at byte address 0.
    logic [rsi_pkg::EpsW-1:0] r_eps;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == rsi_pkg::RegEps) ? rsi_pkg::ApbDataW'(r_eps) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= rsi_pkg::EpsReset;
        end else if (psel && penable && pwrite && paddr[2] == rsi_pkg::RegEps) begin
            r_eps <= pwdata[rsi_pkg::EpsW-1:0];
        end
    end

    // One enable for every stage: advance unless the output word is stuck.
    logic r_out_valid;
    logic w_en;

    assign w_en        = !r_out_valid || o_res.ready;
    assign i_ray.ready = w_en;

    logic signed [COORD_WIDTH-1:0] w_center [3];
    logic signed [COORD_WIDTH-1:0] w_origin [3];
    logic signed [COORD_WIDTH-1:0] w_dir    [3];

    assign w_center = '{i_ray.center_x, i_ray.center_y, i_ray.center_z};
    assign w_origin = '{i_ray.origin_x, i_ray.origin_y, i_ray.origin_z};
    assign w_dir    = '{i_ray.dir_x, i_ray.dir_y, i_ray.dir_z};

    // Coefficients A = v.v, B = v.(e-c), C = |e-c|^2 - r^2 and D = B^2 - A*C.
    logic                      w_q_valid;
    rsi_pkg::t_meta            w_q_meta;
    logic [rsi_pkg::DiscW-1:0] w_q_disc;

    rsi_quad #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_quad (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (i_ray.valid),
        .i_center (w_center),
        .i_origin (w_origin),
        .i_dir    (w_dir),
        .i_radius (i_ray.radius),
        .o_valid  (w_q_valid),
        .o_meta   (w_q_meta),
        .o_disc   (w_q_disc)
    );

    // S = floor(sqrt(D * 2^32)); zero for tangent and missing rays.
    logic                      w_s_valid;
    logic [rsi_pkg::SqrtW-1:0] w_s_root;
    rsi_pkg::t_meta            w_s_meta;

    rsi_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_q_valid),
        .i_disc  (w_q_disc),
        .i_meta  (w_q_meta),
        .o_valid (w_s_valid),
        .o_root  (w_s_root),
        .o_meta  (w_s_meta)
    );

    // Roots (-B*2^16 -/+ S) / A, rounded half away from zero, clamped to 32 bits.
    logic            w_d_valid;
    rsi_pkg::t_roots w_d_roots;

    rsi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_s_valid),
        .i_root  (w_s_root),
        .i_meta  (w_s_meta),
        .o_valid (w_d_valid),
        .o_roots (w_d_roots)
    );

    // Order by magnitude: the + root is nearer only when B is positive.
    logic signed [rsi_pkg::TW-1:0] w_near;
    logic signed [rsi_pkg::TW-1:0] w_far;
    logic signed [rsi_pkg::TW-1:0] w_eps;
    logic                          w_has;

    assign w_has  = (w_d_roots.cnt != rsi_pkg::CntNone);
    assign w_near = !w_has ? '0 : (w_d_roots.b_pos ? w_d_roots.t2 : w_d_roots.t1);
    assign w_far  = !w_has ? '0 : (w_d_roots.b_pos ? w_d_roots.t1 : w_d_roots.t2);
    assign w_eps  = rsi_pkg::TW'(r_eps);

    logic                          r_hit;
    logic [rsi_pkg::CntW-1:0]      r_cnt;
    logic signed [rsi_pkg::TW-1:0] r_near;
    logic signed [rsi_pkg::TW-1:0] r_far;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_d_valid;
        end
    end

    // Hold the result word until taken.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_hit  <= w_has && (w_near > w_eps);
            r_cnt  <= w_d_roots.cnt;
            r_near <= w_near;
            r_far  <= w_far;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.hit        = r_hit;
    assign o_res.root_count = r_cnt;
    assign o_res.near_t     = r_near;
    assign o_res.far_t      = r_far;

endmodule

`default_nettype wire

### bench/ray_sphere_intersect_core_test.sv
// ----------------------------------------------------------------------------
// ray_sphere_intersect_core_test
// Self-checking bench for the ray-sphere core: drives ray words with random
// gaps, stalls the result side, predicts every result word in exact integer
// arithmetic and compares it field by field against the core's output.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module ray_sphere_intersect_core_test;
    import rsi_pkg::*;

    // byte addresses: the epsilon register and one past the register file
    localparam logic [ApbAddrW-1:0] AddrEps  = {RegEps, 2'b00};
    localparam logic [ApbAddrW-1:0] AddrNone = {~RegEps, 2'b00};

    typedef struct {
        logic signed [15:0] cx, cy, cz;
        logic [RadW-1:0]    rad;
        logic signed [15:0] ox, oy, oz;
        logic signed [15:0] vx, vy, vz;
    } t_ray;

    typedef struct {
        logic            hit;
        logic [CntW-1:0] cnt;
        logic [TW-1:0]   near_t;
        logic [TW-1:0]   far_t;
    } t_hit;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ApbAddrW-1:0] paddr = '0;
    logic [ApbDataW-1:0] pwdata = '0;
    logic [ApbDataW-1:0] prdata;
    logic pready;

    rsi_ray_if ray_w ();
    rsi_res_if res_w ();

    ray_sphere_intersect_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ray(ray_w), .o_res(res_w),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    t_hit             pending_hits[$];
    logic [EpsW-1:0]  eps_shadow = EpsReset;
    int               n_errors = 0;
    int               n_words = 0;
    int               n_hits = 0;
    int               n_tangent = 0;
    bit               hold_off = 1'b0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        ray_w.valid = 1'b0;
        ray_w.center_x = '0; ray_w.center_y = '0; ray_w.center_z = '0;
        ray_w.radius = '0;
        ray_w.origin_x = '0; ray_w.origin_y = '0; ray_w.origin_z = '0;
        ray_w.dir_x = '0; ray_w.dir_y = '0; ray_w.dir_z = '0;
        res_w.ready = 1'b0;
    end

    // Round num/den to nearest, halves away from zero, then clamp to Q16.16.
    function automatic logic [TW-1:0] div_round_sat(longint num, longint unsigned den);
        longint unsigned mag, q;
        mag = (num < 0) ? longint'(-num) : longint'(num);
        q = (mag + den / 2) / den;
        if (num < 0) begin
            if (q > 64'd2147483648) return TMin;
            return TW'(-longint'(q));
        end
        if (q > 64'd2147483647) return TMax;
        return TW'(q);
    endfunction

    // Exact quadratic solve: A t^2 + 2B t + C = 0 with d = e - c.
    function automatic t_hit solve_ray(t_ray r);
        longint dx, dy, dz, vx, vy, vz, qa, qb, qc, nb, rr;
        longint unsigned bmag, cmag, root, cand;
        logic [127:0] bb, ac, disc, sh, sq;
        t_hit h;
        h = '{1'b0, CntNone, '0, '0};
        vx = longint'(r.vx); vy = longint'(r.vy); vz = longint'(r.vz);
        dx = longint'(r.ox) - longint'(r.cx);
        dy = longint'(r.oy) - longint'(r.cy);
        dz = longint'(r.oz) - longint'(r.cz);
        rr = longint'({1'b0, r.rad});
        qa = vx * vx + vy * vy + vz * vz;
        qb = vx * dx + vy * dy + vz * dz;
        qc = dx * dx + dy * dy + dz * dz - rr * rr;
        bmag = (qb < 0) ? -qb : qb;
        cmag = (qc < 0) ? -qc : qc;
        bb = {64'd0, bmag} * {64'd0, bmag};
        ac = {64'd0, qa} * {64'd0, cmag};
        disc = '0;
        if (qa == 0) return h;
        if (qc <= 0) begin
            disc = bb + ac;
            h.cnt = (disc != 0) ? CntTwo : CntOne;
        end else if (bb < ac) begin
            return h;
        end else begin
            disc = bb - ac;
            h.cnt = (disc != 0) ? CntTwo : CntOne;
        end
        nb = -qb * 65536;
        if (h.cnt == CntTwo) begin
            sh = disc << 32;
            root = 0;
            for (int i = 49; i >= 0; i--) begin
                cand = root | (64'd1 << i);
                sq = {64'd0, cand} * {64'd0, cand};
                if (sq <= sh) root = cand;
            end
            // larger-magnitude root is the minus branch only when B > 0
            if (qb > 0) begin
                h.near_t = div_round_sat(nb + longint'(root), qa);
                h.far_t  = div_round_sat(nb - longint'(root), qa);
            end else begin
                h.near_t = div_round_sat(nb - longint'(root), qa);
                h.far_t  = div_round_sat(nb + longint'(root), qa);
            end
        end else begin
            h.near_t = div_round_sat(nb, qa);
            h.far_t  = h.near_t;
        end
        h.hit = longint'($signed(h.near_t)) > longint'({1'b0, eps_shadow});
        return h;
    endfunction

    // Mostly short gaps, a few long ones.
    function automatic int pick_gap();
        int p;
        p = int'($urandom_range(99));
        if (p < 60) return 0;
        if (p < 94) return int'($urandom_range(3, 1));
        return int'($urandom_range(40, 8));
    endfunction

    function automatic logic signed [15:0] clip16(longint v);
        if (v > 32767) return 16'sh7FFF;
        if (v < -32768) return 16'sh8000;
        return v[15:0];
    endfunction

    // Offer one ray word, hold it until taken, record its expected result.
    task automatic send_ray(t_ray r, int gap);
        t_hit h;
        ray_w.valid    <= 1'b1;
        ray_w.center_x <= r.cx; ray_w.center_y <= r.cy; ray_w.center_z <= r.cz;
        ray_w.radius   <= r.rad;
        ray_w.origin_x <= r.ox; ray_w.origin_y <= r.oy; ray_w.origin_z <= r.oz;
        ray_w.dir_x    <= r.vx; ray_w.dir_y    <= r.vy; ray_w.dir_z    <= r.vz;
        do @(posedge i_clk); while (!ray_w.ready);
        h = solve_ray(r);
        pending_hits.push_back(h);
        n_words++;
        if (h.hit) n_hits++;
        if (h.cnt == CntOne) n_tangent++;
        if (gap > 0) begin
            ray_w.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic park_ray_side();
        ray_w.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Wait for the pipe to empty; every word yields a result, plus a margin.
    task automatic drain_results();
        park_ray_side();
        while (pending_hits.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [ApbAddrW-1:0] addr, logic [ApbDataW-1:0] data);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (addr == AddrEps) eps_shadow = data[EpsW-1:0];
        @(posedge i_clk);
    endtask

    function automatic t_ray make_ray(int cx, int cy, int cz, int rad,
                                      int ox, int oy, int oz, int vx, int vy, int vz);
        t_ray r;
        r.cx = 16'(cx); r.cy = 16'(cy); r.cz = 16'(cz); r.rad = RadW'(rad);
        r.ox = 16'(ox); r.oy = 16'(oy); r.oz = 16'(oz);
        r.vx = 16'(vx); r.vy = 16'(vy); r.vz = 16'(vz);
        return r;
    endfunction

    function automatic t_ray random_ray();
        t_ray r;
        int p;
        p = int'($urandom_range(99));
        r.cx = 16'($urandom); r.cy = 16'($urandom); r.cz = 16'($urandom);
        r.rad = RadW'($urandom);
        r.ox = 16'($urandom); r.oy = 16'($urandom); r.oz = 16'($urandom);
        r.vx = 16'($urandom); r.vy = 16'($urandom); r.vz = 16'($urandom);
        if (p >= 35) begin
            // aim the ray near the center so crossings and hits dominate
            r.cx = $signed(r.cx) >>> 2; r.cy = $signed(r.cy) >>> 2; r.cz = $signed(r.cz) >>> 2;
            r.ox = $signed(r.ox) >>> 2; r.oy = $signed(r.oy) >>> 2; r.oz = $signed(r.oz) >>> 2;
            r.rad = r.rad >> $urandom_range(4, 1);
            r.vx = clip16(longint'(r.cx) - r.ox + $signed(16'($urandom)) / 64);
            r.vy = clip16(longint'(r.cy) - r.oy + $signed(16'($urandom)) / 64);
            r.vz = clip16(longint'(r.cz) - r.oz + $signed(16'($urandom)) / 64);
            if (p >= 90) begin
                r.vx = -r.vx; r.vy = -r.vy; r.vz = -r.vz;
            end
        end
        return r;
    endfunction

    // Ready side: random stalls, or one long hold-off on request.
    initial begin
        @(posedge i_rst_n);
        forever begin
            if (hold_off) begin
                res_w.ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                hold_off = 1'b0;
            end else begin
                res_w.ready <= 1'b1;
                repeat ($urandom_range(30, 1)) @(posedge i_clk);
                if ($urandom_range(3) == 0) begin
                    res_w.ready <= 1'b0;
                    repeat (pick_gap() + 1) @(posedge i_clk);
                end
            end
        end
    end

    // Compare every accepted result word with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && res_w.valid && res_w.ready) begin
            if (pending_hits.size() == 0) begin
                $display("%0t: result word with nothing pending: hit %0d cnt %0d near %h far %h",
                         $time, res_w.hit, res_w.root_count, res_w.near_t, res_w.far_t);
                n_errors++;
            end else begin
                t_hit h;
                h = pending_hits.pop_front();
                if (res_w.hit !== h.hit) begin
                    $display("%0t: hit expected %0d actual %0d", $time, h.hit, res_w.hit);
                    n_errors++;
                end
                if (res_w.root_count !== h.cnt) begin
                    $display("%0t: root_count expected %0d actual %0d",
                             $time, h.cnt, res_w.root_count);
                    n_errors++;
                end
                if (res_w.near_t !== h.near_t) begin
                    $display("%0t: near_t expected %h actual %h", $time, h.near_t, res_w.near_t);
                    n_errors++;
                end
                if (res_w.far_t !== h.far_t) begin
                    $display("%0t: far_t expected %h actual %h", $time, h.far_t, res_w.far_t);
                    n_errors++;
                end
            end
        end
    end

    // Corner geometry: extremes, zero direction, tangent, miss, inside, behind.
    task automatic test_directed();
        send_ray(make_ray(0, 0, 0, 4096, -8192, 0, 0, 4096, 0, 0), 0);        // crossing
        send_ray(make_ray(0, 0, 0, 4096, -8192, 4096, 0, 4096, 0, 0), 0);     // tangent
        send_ray(make_ray(0, 0, 0, 4096, -8192, 8192, 0, 4096, 0, 0), 1);     // miss
        send_ray(make_ray(0, 0, 0, 4096, 0, 0, 0, 0, 4096, 0), 0);            // inside, B = 0
        send_ray(make_ray(0, 0, 0, 4096, -8192, 0, 0, -4096, 0, 0), 0);       // sphere behind
        send_ray(make_ray(100, 200, 300, 4096, 5, 6, 7, 0, 0, 0), 2);         // zero direction
        send_ray(make_ray(0, 0, 0, 32767, 0, 0, 0, 1, 0, 0), 0);              // roots near the Q16.16 limits
        send_ray(make_ray(-32768, -32768, -32768, 32767, 32767, 32767, 32767,
                          -32768, -32768, -32768), 0);
        send_ray(make_ray(32767, 32767, 32767, 32767, -32768, -32768, -32768,
                          32767, 32767, 32767), 0);
        send_ray(make_ray(32767, -32768, 32767, 0, -32768, 32767, -32768,
                          32767, -32768, 32767), 0);
        send_ray(make_ray(0, 0, 0, 0, -4096, 0, 0, 4096, 0, 0), 0);           // point sphere
        send_ray(make_ray(0, 0, 0, 4096, -4096, 0, 0, 4096, 0, 0), 3);        // origin on surface
        send_ray(make_ray(0, 0, 0, 32767, 32767, 32767, 32767, -1, -1, -1), 0);
        send_ray(make_ray(-32768, 0, 0, 1, 32767, 0, 0, -32768, 0, 0), 0);
        send_ray(make_ray(0, 0, 0, 32767, 0, 0, 0, -32768, -32768, -32768), 0);
        drain_results();
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++) send_ray(random_ray(), pick_gap());
        drain_results();
    endtask

    // Hold the result side while rays keep coming, so the input stalls.
    task automatic test_backpressure();
        hold_off = 1'b1;
        for (int i = 0; i < 200; i++) send_ray(random_ray(), 0);
        drain_results();
    endtask

    task automatic test_epsilon_sweep();
        logic [ApbDataW-1:0] eps_set[5];
        eps_set = '{32'd0, 32'd65535, 32'd1, 32'($urandom_range(65535)), 32'd66};
        foreach (eps_set[k]) begin
            apb_write(AddrEps, eps_set[k]);
            send_ray(make_ray(0, 0, 0, 4096, -4096, 0, 0, 4096, 0, 0), 0); // near root 0
            send_ray(make_ray(0, 0, 0, 4096, -8192, 0, 0, 4096, 0, 0), 0); // near root 1.0
            test_random(60);
        end
        // no register behind this address: the write must not touch the epsilon
        apb_write(AddrNone, 32'd0);
        test_random(40);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(350);
        test_backpressure();
        test_epsilon_sweep();
        apb_write(AddrEps, 32'd0);
        test_random(100);
        apb_write(AddrEps, 32'd66);
        test_random(100);
        repeat (200) @(posedge i_clk);
        $display("Checked %0d ray words: %0d hits, %0d tangents, epsilon swept 0..65535.",
                 n_words, n_hits, n_tangent);
        if (n_errors == 0 && pending_hits.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Timed out with %0d results pending.", pending_hits.size());
        $display("RESULT: ERROR");
        $finish;
    end
endmodule

`default_nettype wire
